/* rtl/core/hmfs_pkg.sv */
// ----------------------------------------------------------------------------
// hmfs_pkg
// Shared types, sizes and media name tables for the media format selector.
// ----------------------------------------------------------------------------
`default_nettype none

package hmfs_pkg;

    // byte queue between front and back
    localparam int FQ_DEPTH = 4;
    localparam int FQ_AW    = $clog2(FQ_DEPTH);
    localparam int FQ_CW    = $clog2(FQ_DEPTH + 1);

    // result queue at the back
    localparam int OQ_DEPTH = 2;
    localparam int OQ_AW    = $clog2(OQ_DEPTH);
    localparam int OQ_CW    = $clog2(OQ_DEPTH + 1);

    localparam logic [4:0] LEN_X   = 5'd22;
    localparam logic [4:0] LEN_P   = 5'd20;
    localparam logic [4:0] POS_MAX = 5'd23;

    localparam logic [8*22-1:0] NAME_X = "application/x-protobuf";
    localparam logic [8*20-1:0] NAME_P = "application/protobuf";

    localparam logic CMD_CTYPE  = 1'b0;
    localparam logic CMD_ACCEPT = 1'b1;

    localparam logic FMT_JSON     = 1'b0;
    localparam logic FMT_PROTOBUF = 1'b1;

    typedef enum logic [3:0] {
        PH_LEAD   = 4'b0001,
        PH_BODY   = 4'b0010,
        PH_TRAIL  = 4'b0100,
        PH_PARAMS = 4'b1000
    } phase_t;

    typedef enum logic [7:0] {
        QS_NONE    = 8'b0000_0001,
        QS_SEMI    = 8'b0000_0010,
        QS_Q       = 8'b0000_0100,
        QS_EQ      = 8'b0000_1000,
        QS_FOUND   = 8'b0001_0000,
        QS_DOT     = 8'b0010_0000,
        QS_ZERO    = 8'b0100_0000,
        QS_NONZERO = 8'b1000_0000
    } qscan_t;

    // one classified word
    typedef struct packed {
        logic       cmd;
        logic       empty;
        logic       last;
        logic [7:0] ch;        // lowercased byte
        logic       is_semi;
        logic       is_space;
        logic       is_comma;
        logic       is_dot;
        logic       is_zero;
        logic       is_eq;
        logic       is_q;      // raw lowercase q only
    } item_t;

    typedef struct packed {
        logic header_done;
        logic format;
    } result_t;

    function automatic logic [7:0] name_x_char(input logic [4:0] pos);
        logic [4:0] d;
        logic [7:0] sh;
        d  = LEN_X - 5'd1 - pos;
        sh = {d, 3'b000};
        return NAME_X[sh +: 8];
    endfunction

    function automatic logic [7:0] name_p_char(input logic [4:0] pos);
        logic [4:0] d;
        logic [7:0] sh;
        d  = LEN_P - 5'd1 - pos;
        sh = {d, 3'b000};
        return NAME_P[sh +: 8];
    endfunction

endpackage

`default_nettype wire

/* rtl/core/http_media_format_selector.sv */
// ----------------------------------------------------------------------------
// http_media_format_selector
// Picks the request and response wire format from Content-Type and Accept.
// ----------------------------------------------------------------------------
// Input channel: one header value byte per word, taken at an edge where push
// is high and full is low. command tells Content-Type from Accept, last_byte
// closes a value, value_empty stands for a value with no bytes at all.
// Result channel: while empty is low, header_done and format show the oldest
// result; it is taken at an edge where pop is high. A result comes for each
// closed or empty value: header_done 0 gives the request format, 1 the
// response format.
// Throughput is one word per cycle while full stays low. A word is held in a
// four entry byte queue, parsed combinationally by the back end at its head,
// and its result is registered in the result queue before it can be popped.
// When pop is held low, results collect in a two entry result queue, then the
// byte queue fills and full rises; nothing is dropped.
// Reset empties both queues, clears the parse state and sets the remembered
// request format to JSON.
// ----------------------------------------------------------------------------
`default_nettype none

module http_media_format_selector
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       push,
    output logic            full,
    input  wire logic       command,
    input  wire logic [7:0] data_byte,
    input  wire logic       value_empty,
    input  wire logic       last_byte,
    output logic            empty,
    input  wire logic       pop,
    output logic            header_done,
    output logic            format
);

    hmfs_pkg::item_t head;
    logic            head_valid;
    logic            head_take;

    hmfs_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .command     (command),
        .data_byte   (data_byte),
        .value_empty (value_empty),
        .last_byte   (last_byte),
        .head        (head),
        .head_valid  (head_valid),
        .head_take   (head_take)
    );

    hmfs_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head),
        .head_valid  (head_valid),
        .head_take   (head_take),
        .empty       (empty),
        .pop         (pop),
        .header_done (header_done),
        .format      (format)
    );

endmodule

`default_nettype wire

/* rtl/core/hmfs_front.sv */
// ----------------------------------------------------------------------------
// hmfs_front
// Accepts header bytes, classifies them and holds them in a short queue.
// ----------------------------------------------------------------------------
`default_nettype none

module hmfs_front
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                push,
    output logic                     full,
    input  wire logic                command,
    input  wire logic [7:0]          data_byte,
    input  wire logic                value_empty,
    input  wire logic                last_byte,
    output hmfs_pkg::item_t          head,
    output logic                     head_valid,
    input  wire logic                head_take
);

    hmfs_pkg::item_t                 mem_reg [hmfs_pkg::FQ_DEPTH];
    logic [hmfs_pkg::FQ_AW-1:0]      wr_ptr_reg;
    logic [hmfs_pkg::FQ_AW-1:0]      wr_ptr_next;
    logic [hmfs_pkg::FQ_AW-1:0]      rd_ptr_reg;
    logic [hmfs_pkg::FQ_AW-1:0]      rd_ptr_next;
    logic [hmfs_pkg::FQ_CW-1:0]      cnt_reg;
    logic [hmfs_pkg::FQ_CW-1:0]      cnt_next;
    hmfs_pkg::item_t                 cls;
    logic                            wr_en;
    logic                            rd_en;

    assign full       = (cnt_reg == hmfs_pkg::FQ_CW'(hmfs_pkg::FQ_DEPTH));
    assign head_valid = (cnt_reg != '0);
    assign head       = mem_reg[rd_ptr_reg];
    assign wr_en      = push && !full;
    assign rd_en      = head_take && head_valid;

    always_comb
    begin
        cls.cmd      = command;
        cls.empty    = value_empty;
        cls.last     = last_byte;
        cls.ch       = (data_byte >= "A" && data_byte <= "Z") ? data_byte + 8'd32 : data_byte;
        cls.is_semi  = (data_byte == ";");
        cls.is_space = (data_byte == " ");
        cls.is_comma = (data_byte == ",");
        cls.is_dot   = (data_byte == ".");
        cls.is_zero  = (data_byte == "0");
        cls.is_eq    = (data_byte == "=");
        cls.is_q     = (data_byte == "q");
    end

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (wr_en)
        begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (rd_en)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (wr_en && !rd_en)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (rd_en && !wr_en)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_ptr_reg] <= cls;
        end
    end

`ifndef SYNTHESIS
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= hmfs_pkg::FQ_CW'(hmfs_pkg::FQ_DEPTH))
        else $error("byte queue count out of range");

    a_cnt_up: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_en && !rd_en) |=> cnt_reg == $past(cnt_reg) + 1'b1)
        else $error("byte queue count did not rise on write");

    a_cnt_down: assert property (@(posedge clk) disable iff (!rst_n)
        (rd_en && !wr_en) |=> cnt_reg == $past(cnt_reg) - 1'b1)
        else $error("byte queue count did not fall on read");
`endif

endmodule

`default_nettype wire

/* rtl/core/hmfs_back.sv */
// ----------------------------------------------------------------------------
// hmfs_back
// Parses queued header words, picks the media format and queues the results.
// ----------------------------------------------------------------------------
`default_nettype none

module hmfs_back
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire hmfs_pkg::item_t     head,
    input  wire logic                head_valid,
    output logic                     head_take,
    output logic                     empty,
    input  wire logic                pop,
    output logic                     header_done,
    output logic                     format
);

    hmfs_pkg::phase_t                ph_reg, ph_next, m_ph;
    hmfs_pkg::qscan_t                qs_reg, qs_next, m_qs;
    logic [4:0]                      pos_reg, pos_next, m_pos, pos_inc;
    logic [1:0]                      al_reg, al_next, m_al, fed_al;
    logic                            pf_reg, pf_next;
    logic                            rf_reg, rf_next;

    hmfs_pkg::result_t               oq_reg [hmfs_pkg::OQ_DEPTH];
    logic [hmfs_pkg::OQ_AW-1:0]      owr_reg;
    logic [hmfs_pkg::OQ_AW-1:0]      ord_reg;
    logic [hmfs_pkg::OQ_CW-1:0]      ocnt_reg;
    logic [hmfs_pkg::OQ_CW-1:0]      ocnt_next;

    logic                            fx, fp;
    logic                            m_match, cur_match, cur_skip, m_skip, found;
    logic                            res_wr, rd_en;
    hmfs_pkg::result_t               res;

    assign head_take   = head_valid && (ocnt_reg != hmfs_pkg::OQ_CW'(hmfs_pkg::OQ_DEPTH));
    assign empty       = (ocnt_reg == '0);
    assign rd_en       = pop && !empty;
    assign header_done = oq_reg[ord_reg].header_done;
    assign format      = oq_reg[ord_reg].format;

    // name compare for the current position
    always_comb
    begin
        fx      = (pos_reg < hmfs_pkg::LEN_X) && (head.ch == hmfs_pkg::name_x_char(pos_reg));
        fp      = (pos_reg < hmfs_pkg::LEN_P) && (head.ch == hmfs_pkg::name_p_char(pos_reg));
        fed_al  = al_reg & {fp, fx};
        pos_inc = (pos_reg < hmfs_pkg::POS_MAX) ? pos_reg + 5'd1 : pos_reg;
    end

    // media type step
    always_comb
    begin
        m_ph  = ph_reg;
        m_pos = pos_reg;
        m_al  = al_reg;
        unique case (ph_reg)
            hmfs_pkg::PH_LEAD:
            begin
                if (head.is_semi)
                begin
                    m_ph = hmfs_pkg::PH_PARAMS;
                end
                else if (!head.is_space)
                begin
                    m_ph  = hmfs_pkg::PH_BODY;
                    m_pos = pos_inc;
                    m_al  = fed_al;
                end
            end
            hmfs_pkg::PH_BODY:
            begin
                if (head.is_semi)
                begin
                    m_ph = hmfs_pkg::PH_PARAMS;
                end
                else if (head.is_space)
                begin
                    m_ph = hmfs_pkg::PH_TRAIL;
                end
                else
                begin
                    m_pos = pos_inc;
                    m_al  = fed_al;
                end
            end
            hmfs_pkg::PH_TRAIL:
            begin
                if (head.is_semi)
                begin
                    m_ph = hmfs_pkg::PH_PARAMS;
                end
                else if (!head.is_space)
                begin
                    // interior space, no match possible
                    m_ph = hmfs_pkg::PH_BODY;
                    m_al = 2'b00;
                end
            end
            default:
            begin
                m_ph = ph_reg;
            end
        endcase
    end

    // q=0 scan over the parameters
    always_comb
    begin
        m_qs = qs_reg;
        unique case (qs_reg)
            hmfs_pkg::QS_NONE:
            begin
                m_qs = head.is_semi ? hmfs_pkg::QS_SEMI : hmfs_pkg::QS_NONE;
            end
            hmfs_pkg::QS_SEMI:
            begin
                if (head.is_q)
                    m_qs = hmfs_pkg::QS_Q;
                else
                    m_qs = head.is_semi ? hmfs_pkg::QS_SEMI : hmfs_pkg::QS_NONE;
            end
            hmfs_pkg::QS_Q:
            begin
                if (head.is_eq)
                    m_qs = hmfs_pkg::QS_EQ;
                else
                    m_qs = head.is_semi ? hmfs_pkg::QS_SEMI : hmfs_pkg::QS_NONE;
            end
            hmfs_pkg::QS_EQ:
            begin
                if (head.is_zero)
                    m_qs = hmfs_pkg::QS_FOUND;
                else
                    m_qs = head.is_semi ? hmfs_pkg::QS_SEMI : hmfs_pkg::QS_NONE;
            end
            hmfs_pkg::QS_FOUND:
            begin
                if (head.is_semi || head.is_space)
                    m_qs = hmfs_pkg::QS_ZERO;
                else if (head.is_dot)
                    m_qs = hmfs_pkg::QS_DOT;
                else
                    m_qs = hmfs_pkg::QS_NONZERO;
            end
            hmfs_pkg::QS_DOT:
            begin
                if (head.is_zero)
                    m_qs = hmfs_pkg::QS_DOT;
                else if (head.is_semi || head.is_space)
                    m_qs = hmfs_pkg::QS_ZERO;
                else
                    m_qs = hmfs_pkg::QS_NONZERO;
            end
            hmfs_pkg::QS_ZERO, hmfs_pkg::QS_NONZERO:
            begin
                m_qs = qs_reg;
            end
            default:
            begin
                m_qs = qs_reg;
            end
        endcase
    end

    always_comb
    begin
        m_match   = (m_al[0] && m_pos == hmfs_pkg::LEN_X) || (m_al[1] && m_pos == hmfs_pkg::LEN_P);
        cur_match = (al_reg[0] && pos_reg == hmfs_pkg::LEN_X)
                 || (al_reg[1] && pos_reg == hmfs_pkg::LEN_P);
        // found, after a dot, or zero quality: entry is refused
        cur_skip  = (qs_reg == hmfs_pkg::QS_FOUND) || (qs_reg == hmfs_pkg::QS_DOT)
                 || (qs_reg == hmfs_pkg::QS_ZERO);
        m_skip    = (m_qs == hmfs_pkg::QS_FOUND) || (m_qs == hmfs_pkg::QS_DOT)
                 || (m_qs == hmfs_pkg::QS_ZERO);
    end

    always_comb
    begin
        ph_next = ph_reg;
        pos_next = pos_reg;
        al_next = al_reg;
        qs_next = qs_reg;
        pf_next = pf_reg;
        rf_next = rf_reg;
        res_wr  = 1'b0;
        res.header_done = hmfs_pkg::CMD_CTYPE;
        res.format      = hmfs_pkg::FMT_JSON;
        found   = 1'b0;
        if (head_take)
        begin
            if (head.empty)
            begin
                ph_next  = hmfs_pkg::PH_LEAD;
                pos_next = '0;
                al_next  = 2'b11;
                qs_next  = hmfs_pkg::QS_NONE;
                res_wr   = 1'b1;
                if (head.cmd == hmfs_pkg::CMD_CTYPE)
                begin
                    rf_next = hmfs_pkg::FMT_JSON;
                end
                else
                begin
                    pf_next         = 1'b0;
                    res.header_done = hmfs_pkg::CMD_ACCEPT;
                    res.format      = rf_reg;
                end
            end
            else if (head.cmd == hmfs_pkg::CMD_CTYPE)
            begin
                ph_next  = m_ph;
                pos_next = m_pos;
                al_next  = m_al;
                if (head.last)
                begin
                    ph_next    = hmfs_pkg::PH_LEAD;
                    pos_next   = '0;
                    al_next    = 2'b11;
                    qs_next    = hmfs_pkg::QS_NONE;
                    rf_next    = m_match;
                    res_wr     = 1'b1;
                    res.format = m_match;
                end
            end
            else
            begin
                if (head.is_comma)
                begin
                    found    = pf_reg || (!cur_skip && cur_match);
                    ph_next  = hmfs_pkg::PH_LEAD;
                    pos_next = '0;
                    al_next  = 2'b11;
                    qs_next  = hmfs_pkg::QS_NONE;
                end
                else
                begin
                    found    = pf_reg || (head.last && !m_skip && m_match);
                    ph_next  = m_ph;
                    pos_next = m_pos;
                    al_next  = m_al;
                    qs_next  = m_qs;
                end
                pf_next = found;
                if (head.last)
                begin
                    ph_next         = hmfs_pkg::PH_LEAD;
                    pos_next        = '0;
                    al_next         = 2'b11;
                    qs_next         = hmfs_pkg::QS_NONE;
                    pf_next         = 1'b0;
                    res_wr          = 1'b1;
                    res.header_done = hmfs_pkg::CMD_ACCEPT;
                    res.format      = found;
                end
            end
        end
    end

    always_comb
    begin
        ocnt_next = ocnt_reg;
        if (res_wr && !rd_en)
        begin
            ocnt_next = ocnt_reg + 1'b1;
        end
        else if (rd_en && !res_wr)
        begin
            ocnt_next = ocnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ph_reg   <= hmfs_pkg::PH_LEAD;
            pos_reg  <= '0;
            al_reg   <= 2'b11;
            qs_reg   <= hmfs_pkg::QS_NONE;
            pf_reg   <= 1'b0;
            rf_reg   <= hmfs_pkg::FMT_JSON;
            owr_reg  <= '0;
            ord_reg  <= '0;
            ocnt_reg <= '0;
        end
        else
        begin
            ph_reg   <= ph_next;
            pos_reg  <= pos_next;
            al_reg   <= al_next;
            qs_reg   <= qs_next;
            pf_reg   <= pf_next;
            rf_reg   <= rf_next;
            ocnt_reg <= ocnt_next;
            if (res_wr)
            begin
                owr_reg <= owr_reg + 1'b1;
            end
            if (rd_en)
            begin
                ord_reg <= ord_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_wr)
        begin
            oq_reg[owr_reg] <= res;
        end
    end

`ifndef SYNTHESIS
    a_ocnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        ocnt_reg <= hmfs_pkg::OQ_CW'(hmfs_pkg::OQ_DEPTH))
        else $error("result queue count out of range");

    a_end_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        (head_take && (head.empty || head.last)) |=> !empty)
        else $error("concluded header left no result");

    a_accept_clears_found: assert property (@(posedge clk) disable iff (!rst_n)
        (head_take && head.cmd == hmfs_pkg::CMD_ACCEPT && (head.empty || head.last))
        |=> !pf_reg)
        else $error("protobuf flag survived the end of an accept value");
`endif

endmodule

`default_nettype wire

/* test/http_media_format_selector_test.sv */
// ----------------------------------------------------------------------------
// http_media_format_selector_test
// Feeds Content-Type and Accept header bytes with random gaps on both queue
// sides, predicts each request and response format, and checks every popped
// result in order. A short table of hand-picked headers runs first, then
// generated requests with mixed case, padding, quality parameters and noise.
// ----------------------------------------------------------------------------
module http_media_format_selector_test;

    localparam int WORD_TARGET   = 1100;
    localparam int STALL_LIMIT   = 400;

    typedef struct {
        logic  cmd;
        string text;
        bit    cut;       // value goes on in the next row
        int    flip;      // byte index where the command toggles, -1 for none
        bit    pinned;
        logic  pin_fmt;
    } header_row_t;

    logic       clk;
    logic       rst_n;
    logic       push;
    logic       full;
    logic       command;
    logic [7:0] data_byte;
    logic       value_empty;
    logic       last_byte;
    logic       empty;
    logic       pop;
    logic       header_done;
    logic       format;

    // hand-typed format travelling with the word that closes a value
    logic       pin_on;
    logic       pin_fmt;

    // predictor state
    hmfs_pkg::phase_t  phase;
    logic [4:0]        name_pos;
    logic [1:0]        alive;
    hmfs_pkg::qscan_t  qstate;
    logic              pb_seen;
    logic              req_fmt;

    hmfs_pkg::result_t awaited_results[$];
    int         errors;
    int         words_sent;
    int         quiet_cycles;
    bit         send_burst;
    bit         recv_burst;
    bit         noisy;

    header_row_t dir_rows[14] = '{
        '{hmfs_pkg::CMD_ACCEPT, "", 1'b0, -1, 1'b1, hmfs_pkg::FMT_JSON},
        '{hmfs_pkg::CMD_CTYPE, "application/x-protobuf", 1'b0, -1, 1'b1,
          hmfs_pkg::FMT_PROTOBUF},
        '{hmfs_pkg::CMD_ACCEPT, "", 1'b0, -1, 1'b1, hmfs_pkg::FMT_PROTOBUF},
        '{hmfs_pkg::CMD_CTYPE, "  APPLICATION/Protobuf ;charset=utf-8", 1'b0, -1, 1'b1,
          hmfs_pkg::FMT_PROTOBUF},
        '{hmfs_pkg::CMD_ACCEPT, "application/protobuf", 1'b0, -1, 1'b1,
          hmfs_pkg::FMT_PROTOBUF},
        '{hmfs_pkg::CMD_CTYPE, "application/json", 1'b0, -1, 1'b1, hmfs_pkg::FMT_JSON},
        '{hmfs_pkg::CMD_ACCEPT, "application/x-protobuf;q=0", 1'b0, -1, 1'b1,
          hmfs_pkg::FMT_JSON},
        '{hmfs_pkg::CMD_ACCEPT,
          "text/html, application/protobuf;q=0.00 ,application/x-protobuf;q=0.5",
          1'b0, -1, 1'b0, hmfs_pkg::FMT_JSON},
        '{hmfs_pkg::CMD_ACCEPT, "application/ protobuf", 1'b0, -1, 1'b1,
          hmfs_pkg::FMT_JSON},
        '{hmfs_pkg::CMD_CTYPE, "application/x-protobuf,text/plain", 1'b0, -1, 1'b1,
          hmfs_pkg::FMT_JSON},
        '{hmfs_pkg::CMD_CTYPE, "applic", 1'b1, -1, 1'b0, hmfs_pkg::FMT_JSON},
        '{hmfs_pkg::CMD_CTYPE, "", 1'b0, -1, 1'b1, hmfs_pkg::FMT_JSON},
        '{hmfs_pkg::CMD_CTYPE, "application/x-protobuf", 1'b0, 12, 1'b0,
          hmfs_pkg::FMT_JSON},
        '{hmfs_pkg::CMD_ACCEPT,
          "\377application/protobuf;Q=0, */*;q=0.1,application/x-protobuf ;q=0.",
          1'b0, -1, 1'b0, hmfs_pkg::FMT_JSON}
    };

    http_media_format_selector dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .command     (command),
        .data_byte   (data_byte),
        .value_empty (value_empty),
        .last_byte   (last_byte),
        .empty       (empty),
        .pop         (pop),
        .header_done (header_done),
        .format      (format)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // ---------------- predictor ----------------

    function automatic void clear_parse();
        phase    = hmfs_pkg::PH_LEAD;
        name_pos = '0;
        alive    = 2'b11;
        qstate   = hmfs_pkg::QS_NONE;
    endfunction

    function automatic void take_name_char(input logic [7:0] c);
        int k;
        k = int'(name_pos);
        if (k >= int'(hmfs_pkg::LEN_X)
            || c != hmfs_pkg::NAME_X[8*(int'(hmfs_pkg::LEN_X) - 1 - k) +: 8])
            alive[0] = 1'b0;
        if (k >= int'(hmfs_pkg::LEN_P)
            || c != hmfs_pkg::NAME_P[8*(int'(hmfs_pkg::LEN_P) - 1 - k) +: 8])
            alive[1] = 1'b0;
        if (name_pos < hmfs_pkg::POS_MAX)
            name_pos = name_pos + 5'd1;
    endfunction

    function automatic void media_char(input logic [7:0] raw);
        logic [7:0] c;
        c = (raw >= "A" && raw <= "Z") ? raw + 8'd32 : raw;
        case (phase)
            hmfs_pkg::PH_LEAD:
            begin
                if (c == ";")
                    phase = hmfs_pkg::PH_PARAMS;
                else if (c != " ")
                begin
                    phase = hmfs_pkg::PH_BODY;
                    take_name_char(c);
                end
            end
            hmfs_pkg::PH_BODY:
            begin
                if (c == ";")
                    phase = hmfs_pkg::PH_PARAMS;
                else if (c == " ")
                    phase = hmfs_pkg::PH_TRAIL;
                else
                    take_name_char(c);
            end
            hmfs_pkg::PH_TRAIL:
            begin
                // more type characters after a space never match
                if (c == ";")
                    phase = hmfs_pkg::PH_PARAMS;
                else if (c != " ")
                begin
                    alive = 2'b00;
                    phase = hmfs_pkg::PH_BODY;
                end
            end
            default:
                ;
        endcase
    endfunction

    // raw byte here, so an upper case Q never opens a quality match
    function automatic void quality_char(input logic [7:0] c);
        logic [7:0]       want;
        hmfs_pkg::qscan_t step;
        case (qstate)
            hmfs_pkg::QS_NONE, hmfs_pkg::QS_SEMI, hmfs_pkg::QS_Q, hmfs_pkg::QS_EQ:
            begin
                case (qstate)
                    hmfs_pkg::QS_NONE: begin want = ";"; step = hmfs_pkg::QS_SEMI;  end
                    hmfs_pkg::QS_SEMI: begin want = "q"; step = hmfs_pkg::QS_Q;     end
                    hmfs_pkg::QS_Q:    begin want = "="; step = hmfs_pkg::QS_EQ;    end
                    default:           begin want = "0"; step = hmfs_pkg::QS_FOUND; end
                endcase
                if (c == want)
                    qstate = step;
                else if (c == ";")
                    qstate = hmfs_pkg::QS_SEMI;
                else
                    qstate = hmfs_pkg::QS_NONE;
            end
            hmfs_pkg::QS_FOUND:
            begin
                if (c == ";" || c == " ")
                    qstate = hmfs_pkg::QS_ZERO;
                else if (c == ".")
                    qstate = hmfs_pkg::QS_DOT;
                else
                    qstate = hmfs_pkg::QS_NONZERO;
            end
            hmfs_pkg::QS_DOT:
            begin
                if (c == ";" || c == " ")
                    qstate = hmfs_pkg::QS_ZERO;
                else if (c != "0")
                    qstate = hmfs_pkg::QS_NONZERO;
            end
            default:
                ;
        endcase
    endfunction

    function automatic logic name_hit();
        if ((alive[0] && name_pos == hmfs_pkg::LEN_X)
            || (alive[1] && name_pos == hmfs_pkg::LEN_P))
            return hmfs_pkg::FMT_PROTOBUF;
        return hmfs_pkg::FMT_JSON;
    endfunction

    function automatic void close_entry();
        logic skip;
        skip = (qstate == hmfs_pkg::QS_FOUND) || (qstate == hmfs_pkg::QS_DOT)
            || (qstate == hmfs_pkg::QS_ZERO);
        if (!skip && name_hit() == hmfs_pkg::FMT_PROTOBUF)
            pb_seen = 1'b1;
        clear_parse();
    endfunction

    function automatic bit parse_word(input logic cmd, input logic [7:0] b,
                                      input logic emp, input logic last,
                                      output hmfs_pkg::result_t res);
        res = '0;
        if (emp)
        begin
            clear_parse();
            if (cmd == hmfs_pkg::CMD_CTYPE)
            begin
                req_fmt         = hmfs_pkg::FMT_JSON;
                res.header_done = hmfs_pkg::CMD_CTYPE;
                res.format      = hmfs_pkg::FMT_JSON;
            end
            else
            begin
                pb_seen         = 1'b0;
                res.header_done = hmfs_pkg::CMD_ACCEPT;
                res.format      = req_fmt;
            end
            return 1'b1;
        end
        if (cmd == hmfs_pkg::CMD_CTYPE)
        begin
            media_char(b);
            if (!last)
                return 1'b0;
            req_fmt = name_hit();
            clear_parse();
            res.header_done = hmfs_pkg::CMD_CTYPE;
            res.format      = req_fmt;
            return 1'b1;
        end
        if (b == ",")
            close_entry();
        else
        begin
            media_char(b);
            quality_char(b);
        end
        if (!last)
            return 1'b0;
        close_entry();
        res.header_done = hmfs_pkg::CMD_ACCEPT;
        res.format      = pb_seen;
        pb_seen         = 1'b0;
        return 1'b1;
    endfunction

    // ---------------- checking and watchdog ----------------

    always @(posedge clk)
    begin : monitor
        hmfs_pkg::result_t want;
        bit                moved;
        if (rst_n)
        begin
            moved = 1'b0;
            if (pop && !empty)
            begin
                moved = 1'b1;
                if (awaited_results.size() == 0)
                begin
                    $error("unexpected result: header_done %0d format %0d",
                           header_done, format);
                    errors++;
                end
                else
                begin
                    want = awaited_results.pop_front();
                    if (header_done !== want.header_done)
                    begin
                        $error("header_done mismatch: expected %0d, actual %0d",
                               want.header_done, header_done);
                        errors++;
                    end
                    if (format !== want.format)
                    begin
                        $error("format mismatch: expected %0d, actual %0d",
                               want.format, format);
                        errors++;
                    end
                end
            end
            if (push && !full)
            begin
                moved = 1'b1;
                if (parse_word(command, data_byte, value_empty, last_byte, want))
                begin
                    if (pin_on)
                        want.format = pin_fmt;
                    awaited_results.push_back(want);
                end
            end
            quiet_cycles = moved ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    // ---------------- stimulus helpers ----------------

    // gap before the next word, with idle-free stretches now and then
    function automatic int next_gap(inout bit burst);
        if ($urandom_range(0, 49) == 0)
            burst = !burst;
        if (burst)
            return 0;
        return $urandom_range(0, 14);
    endfunction

    task automatic send_word(input logic cmd, input logic [7:0] b, input logic emp,
                             input logic last, input logic pin, input logic pf);
        int gap;
        gap = next_gap(send_burst);
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push        <= 1'b1;
        command     <= cmd;
        data_byte   <= b;
        value_empty <= emp;
        last_byte   <= last;
        pin_on      <= pin;
        pin_fmt     <= pf;
        @(posedge clk);
        while (full !== 1'b0)
            @(posedge clk);
        words_sent++;
    endtask

    task automatic send_value(input logic cmd, input string text, input bit cut,
                              input int flip, input logic pin, input logic pf);
        logic       c;
        logic [7:0] b;
        if (text.len() == 0)
        begin
            // empty value closes whatever last_byte says
            send_word(cmd, 8'($urandom_range(0, 255)), 1'b1, 1'($urandom_range(0, 1)),
                      pin, pf);
            return;
        end
        for (int i = 0; i < text.len(); i++)
        begin
            c = (flip >= 0 && i >= flip) ? ~cmd : cmd;
            b = text[i];
            if (noisy && $urandom_range(0, 39) == 0)
                b = 8'($urandom_range(0, 255));
            send_word(c, b, 1'b0, (i == text.len() - 1) && !cut, pin, pf);
        end
    endtask

    function automatic string pad();
        string s;
        s = "";
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 2)) s = {s, " "};
        return s;
    endfunction

    function automatic string media_name();
        string names[9];
        string s;
        int    k;
        names = '{"application/x-protobuf", "application/protobuf",
                  "application/x-protobuf", "application/protobuf", "application/json",
                  "text/plain", "application/x-protobu", "application/protobuff", "*/*"};
        s = names[$urandom_range(0, 8)];
        for (int i = 0; i < s.len(); i++)
            if (s[i] >= "a" && s[i] <= "z" && $urandom_range(0, 7) == 0)
                s[i] = s[i] - 8'd32;
        if ($urandom_range(0, 11) == 0)
        begin
            k = $urandom_range(0, s.len() - 1);
            s[k] = 8'($urandom_range(1, 255));
        end
        if ($urandom_range(0, 15) == 0)
        begin
            k = $urandom_range(1, s.len() - 1);
            s = {s.substr(0, k - 1), " ", s.substr(k, s.len() - 1)};
        end
        return s;
    endfunction

    function automatic string media_params();
        string opts[16];
        opts = '{";q=0", ";q=0.0", ";q=0.000", ";q=0.5", ";q=1", ";q=0.", ";q=0;level=1",
                 ";q=0 ", ";Q=0", ";q=01", ";a=1;q=0", ";;q=0", ";q=0.01",
                 ";charset=utf-8", "; q=0", ";q=0.0 ;x"};
        if ($urandom_range(0, 1) == 0)
            return "";
        return opts[$urandom_range(0, 15)];
    endfunction

    function automatic string media_entry();
        return {pad(), media_name(), pad(), media_params()};
    endfunction

    function automatic string header_text(input logic cmd);
        string s;
        int    n;
        if ($urandom_range(0, 7) == 0)
            return "";
        s = media_entry();
        if (cmd == hmfs_pkg::CMD_ACCEPT)
        begin
            n = $urandom_range(0, 2);
            repeat (n)
            begin
                if ($urandom_range(0, 15) == 0)
                    s = {s, ","};
                s = {s, ",", media_entry()};
            end
        end
        return s;
    endfunction

    // ---------------- receiver ----------------

    initial
    begin : receiver
        int gap;
        pop = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            gap = next_gap(recv_burst);
            if (gap > 0)
            begin
                pop <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            pop <= 1'b1;
            @(posedge clk);
            while (empty !== 1'b0)
                @(posedge clk);
        end
    end

    // ---------------- main sequence ----------------

    initial
    begin : sender
        string text;
        logic  cmd;
        logic  next_cmd;
        bit    cut;
        bit    paused;
        int    flip;
        rst_n        = 1'b0;
        push         = 1'b0;
        command      = hmfs_pkg::CMD_CTYPE;
        data_byte    = 8'h00;
        value_empty  = 1'b0;
        last_byte    = 1'b0;
        pin_on       = 1'b0;
        pin_fmt      = hmfs_pkg::FMT_JSON;
        errors       = 0;
        words_sent   = 0;
        quiet_cycles = 0;
        send_burst   = 1'b0;
        recv_burst   = 1'b0;
        noisy        = 1'b0;
        paused       = 1'b0;
        next_cmd     = hmfs_pkg::CMD_CTYPE;
        clear_parse();
        pb_seen = 1'b0;
        req_fmt = hmfs_pkg::FMT_JSON;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
            send_value(dir_rows[i].cmd, dir_rows[i].text, dir_rows[i].cut,
                       dir_rows[i].flip, dir_rows[i].pinned, dir_rows[i].pin_fmt);

        noisy = 1'b1;
        while (words_sent < WORD_TARGET)
        begin
            if (!paused && words_sent >= WORD_TARGET / 2)
            begin
                // hold off until the block has drained
                paused = 1'b1;
                push <= 1'b0;
                @(posedge clk);
                while (awaited_results.size() != 0)
                    @(posedge clk);
            end
            cmd = next_cmd;
            if ($urandom_range(0, 5) == 0)
                cmd = 1'($urandom_range(0, 1));
            next_cmd = ~cmd;
            text = header_text(cmd);
            cut  = text.len() > 0 && $urandom_range(0, 24) == 0;
            flip = -1;
            if (text.len() > 1 && $urandom_range(0, 19) == 0)
                flip = $urandom_range(1, text.len() - 1);
            send_value(cmd, text, cut, flip, 1'b0, hmfs_pkg::FMT_JSON);
        end
        push <= 1'b0;

        @(posedge clk);
        while (awaited_results.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (awaited_results.size() != 0)
        begin
            $error("%0d results never arrived", awaited_results.size());
            errors++;
        end
        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
